[src/mbpsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbpsr_pkg
// Types and constants shared by the masked byte pattern scanner modules.
// ----------------------------------------------------------------------------
package mbpsr_pkg;

  // The pattern and replacement registers hold sixteen bytes in two 64-bit halves.
  localparam int MAX_PATTERN = 16;
  localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int ADDR_W      = 32;
  localparam int COUNT_W     = 16;
  localparam int REG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_CARE_MASK      = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_REPLACE_LOW    = 3'd4,
    REG_REPLACE_HIGH   = 3'd5,
    REG_SCAN_MODE      = 3'd6,
    REG_BASE_ADDRESS   = 3'd7
  } reg_index_t;

  typedef logic [7:0] byte_t;
  typedef byte_t [MAX_PATTERN-1:0] window_t;

  typedef struct packed {
    window_t                  pattern;
    logic [MAX_PATTERN-1:0]   care;
    logic [FILL_W-1:0]        length;
    window_t                  replace;
    logic                     mode;
    logic [ADDR_W-1:0]        base;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] match_count;
    logic               first_found;
    logic [ADDR_W-1:0]  first_address;
  } status_t;

  typedef struct packed {
    window_t           pend_bytes;
    logic [FILL_W-1:0] pend_count;
    window_t           tail_bytes;
    logic [FILL_W-1:0] tail_count;
    status_t           status;
  } record_t;

endpackage
`default_nettype wire

[src/mbpsr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbpsr_front
// Window, masked compare and replacement; builds a record for each request that evicts bytes or ends a region.
// ----------------------------------------------------------------------------
module mbpsr_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire mbpsr_pkg::cfg_t          cfg,
  input  wire logic                     accept,
  input  wire logic [7:0]               data_byte,
  input  wire logic                     last_byte,
  output logic                          q_push,
  output mbpsr_pkg::record_t            q_record
);
  import mbpsr_pkg::*;

  window_t               window;
  logic [FILL_W-1:0]     fill;
  logic [ADDR_W-1:0]     offset;
  logic [COUNT_W-1:0]    match_total;
  logic                  found;
  logic [ADDR_W-1:0]     found_addr;

  logic [FILL_W-1:0]     npend;
  logic [FILL_W-1:0]     fill_mid;
  logic [FILL_W-1:0]     fill_next;
  window_t               shifted;
  window_t               window_next;
  logic                  hit;
  logic [ADDR_W-1:0]     offset_next;
  logic [COUNT_W-1:0]    match_total_next;
  logic                  found_next;
  logic [ADDR_W-1:0]     found_addr_next;

  always_comb begin
    npend    = (fill >= cfg.length) ? fill - cfg.length + FILL_W'(1) : '0;
    shifted  = window_t'(window >> {npend, 3'b000});
    fill_mid = fill - npend;
    fill_next = fill_mid + FILL_W'(1);
    window_next = shifted;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (FILL_W'(k) == fill_mid) begin
        window_next[k] = data_byte;
      end
    end
    hit = (fill_next == cfg.length);
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (FILL_W'(k) < cfg.length && cfg.care[k] && window_next[k] != cfg.pattern[k]) begin
        hit = 1'b0;
      end
    end
    offset_next      = offset + ADDR_W'(1);
    match_total_next = match_total;
    found_next       = found;
    found_addr_next  = found_addr;
    if (hit) begin
      if (!found) begin
        found_next      = 1'b1;
        found_addr_next = cfg.base + offset_next - ADDR_W'(cfg.length);
      end
      if (cfg.mode) begin
        window_next = cfg.replace;
        if (match_total != {COUNT_W{1'b1}}) begin
          match_total_next = match_total + COUNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    q_push                       = accept && (npend != '0 || last_byte);
    q_record.pend_bytes          = window;
    q_record.pend_count          = npend;
    q_record.tail_bytes          = window_next;
    q_record.tail_count          = last_byte ? fill_next : '0;
    q_record.status.match_count  = match_total_next;
    q_record.status.first_found  = found_next;
    q_record.status.first_address = found_next ? found_addr_next : '0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
    if (rst) begin
      fill        <= '0;
      offset      <= '0;
      match_total <= '0;
      found       <= 1'b0;
      found_addr  <= '0;
    end else if (accept) begin
      if (last_byte) begin
        fill        <= '0;
        offset      <= '0;
        match_total <= '0;
        found       <= 1'b0;
        found_addr  <= '0;
      end else begin
        fill        <= fill_next;
        offset      <= offset_next;
        match_total <= match_total_next;
        found       <= found_next;
        found_addr  <= found_addr_next;
      end
    end
  end

endmodule
`default_nettype wire

[src/mbpsr_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbpsr_fifo
// Short record queue between the compare front and the output back.
// ----------------------------------------------------------------------------
module mbpsr_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire mbpsr_pkg::record_t push_record,
  input  wire logic               pop,
  output logic                    full,
  output logic                    empty,
  output mbpsr_pkg::record_t      head_record
);
  import mbpsr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  record_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  always_comb begin
    full        = (count == CNT_W'(QUEUE_DEPTH));
    empty       = (count == '0);
    do_push     = push && !full;
    do_pop      = pop && !empty;
    head_record = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_record;
    end
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[src/mbpsr_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbpsr_back
// Unpacks records into single result bytes through two shift registers.
// ----------------------------------------------------------------------------
module mbpsr_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mbpsr_pkg::record_t head_record,
  input  wire logic               q_empty,
  output logic                    q_pop,
  input  wire logic               pop,
  output logic                    empty,
  output logic [7:0]              out_byte,
  output mbpsr_pkg::status_t      status,
  output logic                    end_of_stream
);
  import mbpsr_pkg::*;

  window_t            pend_sr;
  window_t            tail_sr;
  logic [FILL_W-1:0]  pend_cnt;
  logic [FILL_W-1:0]  tail_cnt;
  logic               pend_any;
  logic               busy;
  logic               take;
  logic               done;

  always_comb begin
    pend_any      = (pend_cnt != '0);
    busy          = pend_any || (tail_cnt != '0);
    empty         = !busy;
    out_byte      = pend_any ? pend_sr[0] : tail_sr[0];
    end_of_stream = !pend_any && (tail_cnt == FILL_W'(1));
    take          = pop && busy;
    done          = take && ((pend_any && pend_cnt == FILL_W'(1) && tail_cnt == '0) ||
                             (!pend_any && tail_cnt == FILL_W'(1)));
    q_pop         = !q_empty && (!busy || done);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pend_sr <= head_record.pend_bytes;
      tail_sr <= head_record.tail_bytes;
      status  <= head_record.status;
    end else if (take) begin
      if (pend_any) begin
        pend_sr <= window_t'(pend_sr >> 8);
      end else begin
        tail_sr <= window_t'(tail_sr >> 8);
      end
    end
    if (rst) begin
      pend_cnt <= '0;
      tail_cnt <= '0;
    end else if (q_pop) begin
      pend_cnt <= head_record.pend_count;
      tail_cnt <= head_record.tail_count;
    end else if (take) begin
      if (pend_any) begin
        pend_cnt <= pend_cnt - FILL_W'(1);
      end else begin
        tail_cnt <= tail_cnt - FILL_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[src/masked_byte_pattern_scan_replace.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_replace
// Streams a byte region through a sliding window, matches a masked pattern,
// records the first hit and optionally overwrites every hit in place.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  input     push / full        data_byte, last_byte
//  result    empty / pop        out_byte, match_count, first_found,
//                               first_address, end_of_stream
//  config    cfg_write          cfg_index, cfg_data
//
// A request is compared in the cycle it is accepted; one request per cycle is
// taken while the queue is not full; a request may yield several results, which
// hold the result port one byte per cycle from the unpacking stage while pop is
// held; a two-record queue lets the input run on while results wait.
// Reset is synchronous and restores the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan_replace (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   push,
  output logic                                        full,
  input  wire logic [7:0]                             data_byte,
  input  wire logic                                   last_byte,
  output logic                                        empty,
  input  wire logic                                   pop,
  output logic [7:0]                                  out_byte,
  output logic [15:0]                                 match_count,
  output logic                                        first_found,
  output logic [31:0]                                 first_address,
  output logic                                        end_of_stream,
  input  wire logic                                   cfg_write,
  input  wire logic [mbpsr_pkg::REG_INDEX_W-1:0]      cfg_index,
  input  wire logic [mbpsr_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import mbpsr_pkg::*;

  logic [63:0]          pattern_low;
  logic [63:0]          pattern_high;
  logic [15:0]          care_mask;
  logic [4:0]           pattern_length;
  logic [63:0]          replace_low;
  logic [63:0]          replace_high;
  logic                 scan_mode;
  logic [ADDR_W-1:0]    base_address;

  cfg_t                 cfg;
  logic                 accept;
  logic                 q_push;
  record_t              q_record;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  record_t              head_record;
  status_t              status;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= 16'hFFFF;
      pattern_length <= 5'(MAX_PATTERN);
      replace_low    <= '0;
      replace_high   <= '0;
      scan_mode      <= 1'b0;
      base_address   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_CARE_MASK:      care_mask      <= cfg_data[15:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[4:0];
        REG_REPLACE_LOW:    replace_low    <= cfg_data;
        REG_REPLACE_HIGH:   replace_high   <= cfg_data;
        REG_SCAN_MODE:      scan_mode      <= cfg_data[0];
        REG_BASE_ADDRESS:   base_address   <= cfg_data[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.pattern = window_t'({pattern_high, pattern_low});
    cfg.care    = care_mask[MAX_PATTERN-1:0];
    cfg.replace = window_t'({replace_high, replace_low});
    cfg.mode    = scan_mode;
    cfg.base    = base_address;
    if (pattern_length == '0) begin
      cfg.length = FILL_W'(1);
    end else if (FILL_W'(pattern_length) > FILL_W'(MAX_PATTERN)) begin
      cfg.length = FILL_W'(MAX_PATTERN);
    end else begin
      cfg.length = FILL_W'(pattern_length);
    end
    accept = push && !q_full;
    full   = q_full;
  end

  mbpsr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_push    (q_push),
    .q_record  (q_record)
  );

  mbpsr_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (q_push),
    .push_record (q_record),
    .pop         (q_pop),
    .full        (q_full),
    .empty       (q_empty),
    .head_record (head_record)
  );

  mbpsr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_record   (head_record),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_byte      (out_byte),
    .status        (status),
    .end_of_stream (end_of_stream)
  );

  always_comb begin
    match_count   = status.match_count;
    first_found   = status.first_found;
    first_address = status.first_address;
  end

  a_last_yields_record: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |-> q_push)
    else $error("final request of a region produced no record");

  a_queued_record_reaches_output: assert property (@(posedge clk) disable iff (rst)
    !q_empty |=> !empty)
    else $error("queued record did not reach the result port");

  a_address_zero_without_hit: assert property (@(posedge clk) disable iff (rst)
    !empty && !first_found |-> first_address == '0)
    else $error("first address set without a recorded match");

endmodule
`default_nettype wire

[test/masked_byte_pattern_scan_replace_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_replace_tb
// Streams byte regions through the scanner with random source gaps and
// result stalls. Each accepted request is run through a local copy of the
// window, match and replace rules. Every result is checked against that
// prediction. Directed regions cover matches at both ends, wildcards, both
// modes, length clamping, short regions, a mid-region length cut and address
// wrap. Random regions with embedded patterns follow.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan_replace_tb;
  import mbpsr_pkg::*;

  localparam int SETTLE_CYCLES  = 12;
  localparam int GAP_LIMIT      = 13;
  localparam int RANDOM_ITEMS   = 292;

  typedef struct {
    byte_t data_val;
    logic  is_last;
  } scan_req_t;

  typedef struct {
    byte_t       out_byte;
    logic [15:0] count;
    logic        found;
    logic [31:0] addr;
    logic        eos;
  } scan_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  logic [7:0]             data_byte = '0;
  logic                   last_byte = 1'b0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [7:0]             out_byte;
  logic [15:0]            match_count;
  logic                   first_found;
  logic [31:0]            first_address;
  logic                   end_of_stream;
  logic                   cfg_write = 1'b0;
  logic [REG_INDEX_W-1:0] cfg_index = REG_PATTERN_LOW;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Register copies, at their reset values.
  window_t     pat_bytes = '0;
  window_t     rep_bytes = '0;
  logic [15:0] care_bits = 16'hFFFF;
  logic [4:0]  len_reg = 5'd16;
  logic        replace_mode = 1'b0;
  logic [31:0] region_base = '0;

  // Scan state of the current region.
  byte_t       win [MAX_PATTERN];
  int unsigned win_fill;
  logic [31:0] byte_offset;
  logic [15:0] hit_count;
  logic        hit_seen;
  logic [31:0] hit_addr;

  scan_req_t    pending_reqs[$];
  scan_result_t expected_results[$];

  logic req_taken = 1'b0;
  logic result_taken = 1'b0;
  int   src_wait = 0;
  int   sink_wait = 0;
  int   src_gap_max = GAP_LIMIT;
  int   sink_gap_max = GAP_LIMIT;
  int   fail_count = 0;
  int   result_index = 0;

  masked_byte_pattern_scan_replace dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .match_count   (match_count),
    .first_found   (first_found),
    .first_address (first_address),
    .end_of_stream (end_of_stream),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned active_length();
    if (len_reg == 0) return 1;
    if (len_reg > MAX_PATTERN) return MAX_PATTERN;
    return len_reg;
  endfunction

  function automatic byte_t shift_window();
    byte_t b;
    int    k;
    b = win[0];
    for (k = 0; k < MAX_PATTERN - 1; k++) win[k] = win[k+1];
    win_fill--;
    return b;
  endfunction

  task automatic clear_region();
    int k;
    for (k = 0; k < MAX_PATTERN; k++) win[k] = '0;
    win_fill    = 0;
    byte_offset = '0;
    hit_count   = '0;
    hit_seen    = 1'b0;
    hit_addr    = '0;
  endtask

  task automatic note_result(byte_t b, logic eos);
    scan_result_t r;
    r.out_byte = b;
    r.count    = hit_count;
    r.found    = hit_seen;
    r.addr     = hit_seen ? hit_addr : '0;
    r.eos      = eos;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic scan_byte(byte_t b, logic last);
    byte_t       evicted[$];
    byte_t       flushed;
    int unsigned len;
    int unsigned j;
    logic        hit;
    len = active_length();
    while (win_fill >= len && win_fill > 0) evicted.insert(evicted.size(), shift_window());
    win[win_fill] = b;
    win_fill++;
    byte_offset++;
    if (win_fill == len) begin
      hit = 1'b1;
      for (j = 0; j < len; j++)
        if (care_bits[j] && win[j] != pat_bytes[j]) hit = 1'b0;
      if (hit) begin
        if (!hit_seen) begin
          hit_seen = 1'b1;
          hit_addr = region_base + byte_offset - len;
        end
        if (replace_mode) begin
          for (j = 0; j < len; j++) win[j] = rep_bytes[j];
          if (hit_count != 16'hFFFF) hit_count++;
        end
      end
    end
    foreach (evicted[k]) note_result(evicted[k], 1'b0);
    if (last) begin
      while (win_fill > 0) begin
        flushed = shift_window();
        note_result(flushed, win_fill == 0);
      end
      clear_region();
    end
  endtask

  task automatic check_result();
    scan_result_t want;
    if (expected_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result %0d arrived with none pending: byte %02h eos %0b",
                 result_index, out_byte, end_of_stream);
    end else begin
      want = expected_results.pop_front();
      if (out_byte !== want.out_byte || match_count !== want.count ||
          first_found !== want.found || first_address !== want.addr ||
          end_of_stream !== want.eos) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result %0d: expected byte %02h count %0d found %0b addr %08h eos %0b,",
                   result_index, want.out_byte, want.count, want.found, want.addr,
                   want.eos,
                   " got byte %02h count %0d found %0b addr %08h eos %0b",
                   out_byte, match_count, first_found, first_address, end_of_stream);
      end
    end
    result_index++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_taken    <= 1'b0;
      result_taken <= 1'b0;
    end else begin
      req_taken    <= push && !full;
      result_taken <= pop && !empty;
      if (push && !full) scan_byte(data_byte, last_byte);
      if (pop && !empty) check_result();
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      push     <= 1'b0;
      src_wait <= 0;
    end else if (!push || req_taken) begin
      if (src_wait > 0) begin
        push     <= 1'b0;
        src_wait <= src_wait - 1;
      end else if (pending_reqs.size() != 0) begin
        data_byte <= pending_reqs[0].data_val;
        last_byte <= pending_reqs[0].is_last;
        push      <= 1'b1;
        void'(pending_reqs.pop_front());
        src_wait  <= $urandom_range(0, src_gap_max);
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pop       <= 1'b0;
      sink_wait <= 0;
    end else if (!pop || result_taken) begin
      if (sink_wait > 0) begin
        pop       <= 1'b0;
        sink_wait <= sink_wait - 1;
      end else begin
        pop       <= 1'b1;
        sink_wait <= $urandom_range(0, sink_gap_max);
      end
    end
  end

  task automatic write_reg(reg_index_t idx, logic [63:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_PATTERN_LOW:    pat_bytes[7:0]  = value;
      REG_PATTERN_HIGH:   pat_bytes[15:8] = value;
      REG_CARE_MASK:      care_bits       = value[15:0];
      REG_PATTERN_LENGTH: len_reg         = value[4:0];
      REG_REPLACE_LOW:    rep_bytes[7:0]  = value;
      REG_REPLACE_HIGH:   rep_bytes[15:8] = value;
      REG_SCAN_MODE:      replace_mode    = value[0];
      REG_BASE_ADDRESS:   region_base     = value[31:0];
      default: ;
    endcase
  endtask

  task automatic finish_writes();
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_scan(logic [63:0] pat_lo, logic [63:0] pat_hi, logic [15:0] care,
                              logic [4:0] len, logic [63:0] rep_lo, logic [63:0] rep_hi,
                              logic mode, logic [31:0] base);
    write_reg(REG_PATTERN_LOW, pat_lo);
    write_reg(REG_PATTERN_HIGH, pat_hi);
    write_reg(REG_CARE_MASK, care);
    write_reg(REG_PATTERN_LENGTH, len);
    write_reg(REG_REPLACE_LOW, rep_lo);
    write_reg(REG_REPLACE_HIGH, rep_hi);
    write_reg(REG_SCAN_MODE, mode);
    write_reg(REG_BASE_ADDRESS, base);
    finish_writes();
  endtask

  task automatic send(byte_t b, logic last);
    scan_req_t r;
    r.data_val = b;
    r.is_last  = last;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || push || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random region content, with whole copies of the pattern mixed in.
  task automatic queue_region(int unsigned n_bytes, logic close);
    int unsigned len;
    int unsigned k;
    int unsigned j;
    byte_t       b;
    len = active_length();
    k = 0;
    while (k < n_bytes) begin
      if ($urandom_range(0, 2) == 0) begin
        for (j = 0; j < len && k < n_bytes; j++) begin
          b = care_bits[j] ? pat_bytes[j] : byte_t'($urandom);
          send(b, close && k == n_bytes - 1);
          k++;
        end
      end else begin
        b = $urandom_range(0, 1) ? byte_t'($urandom) : pat_bytes[$urandom_range(0, len - 1)];
        send(b, close && k == n_bytes - 1);
        k++;
      end
    end
  endtask

  function automatic int pick_gap();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return $urandom_range(1, 4);
      default: return GAP_LIMIT;
    endcase
  endfunction

  initial begin
    logic [63:0] pat_pick;
    logic [63:0] rep_pick;
    logic [15:0] care_pick;
    logic [4:0]  len_pick;
    logic [31:0] base_pick;
    int          random_sent;
    int          n;
    int          k;
    clear_region();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Match at the start and at the final window position, replace mode,
    // address wrapping past the top.
    program_scan(64'h5AFF00, '0, 16'hFFFF, 5'd3, 64'h332211, '0, 1'b1, 32'hFFFF_FFFE);
    send(8'h00, 1'b0); send(8'hFF, 1'b0); send(8'h5A, 1'b0);
    send(8'h00, 1'b0); send(8'hFF, 1'b0); send(8'h5A, 1'b1);
    wait_idle();

    // Find-first mode with a wildcard in the middle: two hits, one recorded.
    program_scan(64'h5A0000, '1, 16'hFFFD, 5'd3, '1, '1, 1'b0, 32'h7);
    send(8'h00, 1'b0); send(8'hAB, 1'b0); send(8'h5A, 1'b0);
    send(8'h00, 1'b0); send(8'hCD, 1'b0); send(8'h5A, 1'b1);
    wait_idle();

    // Length above the maximum, region shorter than the pattern.
    program_scan('1, '1, 16'h0000, 5'd31, '1, '1, 1'b1, 32'h0);
    send(8'h12, 1'b0); send(8'hFF, 1'b0); send(8'h00, 1'b1);
    wait_idle();

    // Length zero acts as one.
    program_scan(64'hFF, '0, 16'hFFFF, 5'd0, 64'h0, '0, 1'b1, 32'h0);
    send(8'hFF, 1'b1);
    wait_idle();

    // The next window sees the replaced bytes and no longer matches.
    program_scan(64'hAAAA, '0, 16'hFFFF, 5'd2, 64'hBBAA, '0, 1'b1, 32'h100);
    send(8'hAA, 1'b0); send(8'hAA, 1'b0); send(8'hAA, 1'b1);
    wait_idle();

    // Length cut while a region is open.
    program_scan(64'h07060504, '0, 16'hFFFF, 5'd16, 64'hC3C2C1C0, '1, 1'b1, 32'h8000_0000);
    for (k = 1; k <= 6; k++) send(byte_t'(k), 1'b0);
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, 64'd4);
    finish_writes();
    send(8'h07, 1'b0); send(8'h08, 1'b1);
    wait_idle();

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      pat_pick = {$urandom, $urandom};
      if ($urandom_range(0, 5) == 0) pat_pick = '1;
      rep_pick = $urandom_range(0, 3) == 0 ? pat_pick : {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0:       care_pick = 16'hFFFF;
        1:       care_pick = 16'h0000;
        default: care_pick = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0:       len_pick = 5'd0;
        1:       len_pick = 5'd1;
        2:       len_pick = 5'd16;
        3:       len_pick = $urandom_range(17, 31);
        default: len_pick = $urandom_range(2, 15);
      endcase
      base_pick = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF - $urandom_range(0, 20) : $urandom;
      program_scan(pat_pick, {$urandom, $urandom}, care_pick, len_pick, rep_pick,
                   {$urandom, $urandom}, $urandom_range(0, 1), base_pick);
      src_gap_max  = pick_gap();
      sink_gap_max = pick_gap();
      repeat ($urandom_range(1, 3)) begin
        if (random_sent < RANDOM_ITEMS) begin
          n = $urandom_range(1, 40);
          if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
          queue_region(n, $urandom_range(0, 4) != 0);
          random_sent += n;
        end
      end
      wait_idle();
    end
    send(byte_t'($urandom), 1'b1);
    wait_idle();

    if (fail_count == 0 && expected_results.size() == 0)
      $display("masked_byte_pattern_scan_replace: match");
    else
      $display("masked_byte_pattern_scan_replace: mismatch");
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("masked_byte_pattern_scan_replace: mismatch");
    $finish;
  end

endmodule
